// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the VAG ADPCM decoder.
// ------------------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define VAG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define VAG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vag_pkg.sv =====
// ------------------------------------------------------------------------------------------
// VAG ADPCM decoder package
// Types, constants and filter helpers shared by the decoder modules.
// ------------------------------------------------------------------------------------------
package vag_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] PRED_END = 3'd7;
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FLAGS = 4'd1;
    localparam logic [3:0] POS_LAST = 4'(BLOCK_BYTES - 1);
    localparam logic [15:0] DONE_MAX = 16'hFFFF;

    typedef struct packed {
        logic       is_end;
        logic       clr;
        logic       loop;
        logic       last;
        logic [2:0] pred;
        logic [3:0] shift;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_P0,
        BK_P1,
        BK_P2,
        BK_P3,
        BK_FIN
    } t_back_state;

    function automatic logic signed [7:0] coef_one(input logic [2:0] pred);
        case (pred)
            3'd1: coef_one = 8'sd60;
            3'd2: coef_one = 8'sd115;
            3'd3: coef_one = 8'sd98;
            3'd4: coef_one = 8'sd122;
            default: coef_one = 8'sd0;
        endcase
    endfunction

    function automatic logic signed [7:0] coef_two(input logic [2:0] pred);
        case (pred)
            3'd2: coef_two = -8'sd52;
            3'd3: coef_two = -8'sd55;
            3'd4: coef_two = -8'sd60;
            default: coef_two = 8'sd0;
        endcase
    endfunction

    function automatic logic [31:0] nib_val(input logic [3:0] nib, input logic [3:0] sh);
        logic signed [31:0] x;
        x = {{16{nib[3]}}, nib, 12'b0};
        nib_val = x >>> sh;
    endfunction

endpackage

// ===== rtl/vag_adpcm_block_decoder.sv =====
// A data byte's sample pair passes the filter states P0, P1, P2, P3 and FIN, an end only FIN.
// One byte is in the filter at a time, as its four products share one multiplier.
// Header and flag bytes stay in the front end unless they end the stream, and use no filter time.
// Reset is synchronous and active low; it clears history, position, counters and the queue.
// ------------------------------------------------------------------------------------------
// VAG ADPCM block decoder
// Decodes a 16-byte block stream into 16-bit sample pairs with a two-tap predictor.
// ------------------------------------------------------------------------------------------
`include "assert_macros.svh"

module vag_adpcm_block_decoder #(
    parameter int QUEUE_DEPTH = vag_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_byte_value,
    input  logic               i_first_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_first,
    output logic signed [15:0] o_sample_second,
    output logic               o_loop_point,
    output logic               o_stream_end,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_block_count
);

    logic             w_push;
    logic             w_pop;
    vag_pkg::t_cmd    w_cmd;
    vag_pkg::t_cmd    w_head;
    vag_pkg::t_q_stat w_q_stat;

    assign o_cfg_ready = 1'b1;

    vag_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_byte_value  (i_byte_value),
        .i_first_byte  (i_first_byte),
        .i_cfg_valid   (i_cfg_valid),
        .i_block_count (i_block_count),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    vag_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    vag_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_first  (o_sample_first),
        .o_sample_second (o_sample_second),
        .o_loop_point    (o_loop_point),
        .o_stream_end    (o_stream_end)
    );

    `VAG_ASSERT(a_no_push_full, i_clk, i_rst_n, !(w_push && w_q_stat.full), "Request pushed into a full queue")
    `VAG_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(w_pop && w_q_stat.empty), "Command popped from an empty queue")
    `VAG_ASSERT_IMPL(a_idle_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid, "Result shown straight after reset")

endmodule

// ===== rtl/vag_front.sv =====
// ------------------------------------------------------------------------------------------
// VAG front end
// Tracks the block position, parses header and flag bytes and issues commands.
// ------------------------------------------------------------------------------------------
module vag_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_byte_value,
    input  logic             i_first_byte,
    input  logic             i_cfg_valid,
    input  logic [15:0]      i_block_count,
    input  vag_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output vag_pkg::t_cmd    o_cmd
);

    logic [15:0] r_block_count;
    logic [3:0]  r_pos, n_pos;
    logic [2:0]  r_pred, n_pred;
    logic [3:0]  r_shift, n_shift;
    logic [15:0] r_done, n_done;
    logic        r_stop, n_stop;
    logic        r_loop, n_loop;
    logic        r_clr_pend, n_clr_pend;

    logic        w_acc;
    logic [3:0]  w_pos;
    logic [15:0] w_done;
    logic [15:0] w_done_inc;
    logic        w_stop;
    logic        w_loop;
    logic        w_clr;
    logic [3:0]  w_pred_nib;

    assign o_in_ready = !i_q_stat.full;
    assign w_acc      = i_in_valid && !i_q_stat.full;
    assign w_pred_nib = i_byte_value[7:4];

    always_comb begin
        w_pos      = i_first_byte ? 4'd0 : r_pos;
        w_done     = i_first_byte ? 16'd0 : r_done;
        w_stop     = i_first_byte ? 1'b0 : r_stop;
        w_loop     = i_first_byte ? 1'b0 : r_loop;
        w_clr      = i_first_byte || r_clr_pend;
        w_done_inc = (w_done < vag_pkg::DONE_MAX) ? w_done + 16'd1 : w_done;

        n_pos      = r_pos;
        n_pred     = r_pred;
        n_shift    = r_shift;
        n_done     = r_done;
        n_stop     = r_stop;
        n_loop     = r_loop;
        n_clr_pend = r_clr_pend;

        o_push       = 1'b0;
        o_cmd        = '0;
        o_cmd.pred   = r_pred;
        o_cmd.shift  = r_shift;
        o_cmd.data   = i_byte_value;
        o_cmd.clr    = w_clr;
        o_cmd.loop   = w_loop;
        o_cmd.is_end = 1'b1;

        if (w_acc) begin
            n_pos      = w_pos;
            n_done     = w_done;
            n_stop     = w_stop;
            n_loop     = w_loop;
            n_clr_pend = w_clr;
            if (!w_stop) begin
                if (w_pos == vag_pkg::POS_HEADER) begin
                    if (w_done >= r_block_count || w_pred_nib[2:0] == vag_pkg::PRED_END &&
                        !w_pred_nib[3]) begin
                        o_push = 1'b1;
                        n_stop = 1'b1;
                    end else begin
                        n_pred  = (w_pred_nib < 4'd5) ? w_pred_nib[2:0] : 3'd0;
                        n_shift = i_byte_value[3:0];
                        n_pos   = vag_pkg::POS_FLAGS;
                    end
                end else if (w_pos == vag_pkg::POS_FLAGS) begin
                    if (i_byte_value[0]) begin
                        o_push = 1'b1;
                        n_stop = 1'b1;
                    end else begin
                        n_loop = w_loop || i_byte_value[2];
                        n_pos  = w_pos + 4'd1;
                    end
                end else begin
                    o_push       = 1'b1;
                    o_cmd.is_end = 1'b0;
                    n_loop       = 1'b0;
                    n_clr_pend   = 1'b0;
                    if (w_pos >= vag_pkg::POS_LAST) begin
                        n_pos  = vag_pkg::POS_HEADER;
                        n_done = w_done_inc;
                        if (w_done_inc >= r_block_count) begin
                            o_cmd.last = 1'b1;
                            n_stop     = 1'b1;
                        end
                    end else begin
                        n_pos = w_pos + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
            r_pos         <= '0;
            r_pred        <= '0;
            r_shift       <= '0;
            r_done        <= '0;
            r_stop        <= 1'b0;
            r_loop        <= 1'b0;
            r_clr_pend    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_block_count <= i_block_count;
            end
            r_pos      <= n_pos;
            r_pred     <= n_pred;
            r_shift    <= n_shift;
            r_done     <= n_done;
            r_stop     <= n_stop;
            r_loop     <= n_loop;
            r_clr_pend <= n_clr_pend;
        end
    end

endmodule

// ===== rtl/vag_queue.sv =====
// ------------------------------------------------------------------------------------------
// VAG command queue
// Short first-in first-out buffer between the front end and the filter.
// ------------------------------------------------------------------------------------------
module vag_queue #(
    parameter int DEPTH = vag_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vag_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output vag_pkg::t_cmd    o_head,
    output vag_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vag_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

// ===== rtl/vag_back.sv =====
// ------------------------------------------------------------------------------------------
// VAG filter back end
// Runs the two-tap prediction on one shared multiplier and registers the result.
// ------------------------------------------------------------------------------------------
module vag_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vag_pkg::t_cmd      i_head,
    input  vag_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_first,
    output logic signed [15:0] o_sample_second,
    output logic               o_loop_point,
    output logic               o_stream_end
);

    vag_pkg::t_back_state r_state, n_state;
    vag_pkg::t_cmd        r_cmd, n_cmd;
    logic [31:0]          r_h1, n_h1;
    logic [31:0]          r_h2, n_h2;
    logic [31:0]          r_acc, n_acc;
    logic [31:0]          r_s1, n_s1;
    logic                 r_o_valid, n_o_valid;
    logic [15:0]          r_o_first, n_o_first;
    logic [15:0]          r_o_second, n_o_second;
    logic                 r_o_loop, n_o_loop;
    logic                 r_o_end, n_o_end;

    logic signed [31:0]   w_mul_a;
    logic signed [7:0]    w_mul_c;
    logic signed [39:0]   w_prod;
    logic [31:0]          w_prod32;
    logic [31:0]          w_pred_sh;
    logic [31:0]          w_s2;
    logic                 w_out_free;

    assign w_prod      = w_mul_a * w_mul_c;
    assign w_prod32    = w_prod[31:0];
    assign w_pred_sh   = 32'($signed(r_acc) >>> 6);
    assign w_s2        = vag_pkg::nib_val(r_cmd.data[7:4], r_cmd.shift) + w_pred_sh;
    assign w_out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid     = r_o_valid;
    assign o_sample_first  = r_o_first;
    assign o_sample_second = r_o_second;
    assign o_loop_point    = r_o_loop;
    assign o_stream_end    = r_o_end;

    always_comb begin
        case (r_state)
            vag_pkg::BK_P1: begin
                w_mul_a = r_h2;
                w_mul_c = vag_pkg::coef_two(r_cmd.pred);
            end
            vag_pkg::BK_P2: begin
                w_mul_a = r_h1;
                w_mul_c = vag_pkg::coef_two(r_cmd.pred);
            end
            vag_pkg::BK_P3: begin
                w_mul_a = r_s1;
                w_mul_c = vag_pkg::coef_one(r_cmd.pred);
            end
            default: begin
                w_mul_a = r_h1;
                w_mul_c = vag_pkg::coef_one(r_cmd.pred);
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_h1       = r_h1;
        n_h2       = r_h2;
        n_acc      = r_acc;
        n_s1       = r_s1;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_loop   = r_o_loop;
        n_o_end    = r_o_end;
        o_pop      = 1'b0;

        case (r_state)
            vag_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    if (i_head.clr) begin
                        n_h1 = '0;
                        n_h2 = '0;
                    end
                    n_state = i_head.is_end ? vag_pkg::BK_FIN : vag_pkg::BK_P0;
                end
            end
            vag_pkg::BK_P0: begin
                n_acc   = w_prod32;
                n_state = vag_pkg::BK_P1;
            end
            vag_pkg::BK_P1: begin
                n_acc   = r_acc + w_prod32;
                n_state = vag_pkg::BK_P2;
            end
            vag_pkg::BK_P2: begin
                n_s1    = vag_pkg::nib_val(r_cmd.data[3:0], r_cmd.shift) + w_pred_sh;
                n_acc   = w_prod32;
                n_state = vag_pkg::BK_P3;
            end
            vag_pkg::BK_P3: begin
                n_acc   = r_acc + w_prod32;
                n_state = vag_pkg::BK_FIN;
            end
            vag_pkg::BK_FIN: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    if (r_cmd.is_end) begin
                        n_o_first  = '0;
                        n_o_second = '0;
                        n_o_loop   = 1'b0;
                        n_o_end    = 1'b1;
                    end else begin
                        n_o_first  = r_s1[15:0];
                        n_o_second = w_s2[15:0];
                        n_o_loop   = r_cmd.loop;
                        n_o_end    = r_cmd.last;
                        n_h2       = r_s1;
                        n_h1       = w_s2;
                    end
                    n_state = vag_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = vag_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_acc      <= n_acc;
        r_s1       <= n_s1;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_loop   <= n_o_loop;
        r_o_end    <= n_o_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vag_pkg::BK_IDLE;
            r_h1      <= '0;
            r_h2      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_h1      <= n_h1;
            r_h2      <= n_h2;
            r_o_valid <= n_o_valid;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ------------------------------------------------------------------------------------------
// VAG ADPCM block decoder testbench
// Streams encoded blocks into the decoder and checks every decoded sample pair, loop mark
// and end of stream against a behavioural predictor, with random sender gaps, receiver
// stalls and one long receiver hold that fills the decoder.
// ------------------------------------------------------------------------------------------
module tb_top;

    localparam int ITEMS_TARGET = 640;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 12;

    typedef struct packed {
        logic signed [15:0] s_first;
        logic signed [15:0] s_second;
        logic               loop_pt;
        logic               end_flag;
    } t_pair;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        in_first = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_count = 16'h0000;

    logic               in_ready;
    logic               out_valid;
    logic signed [15:0] out_first;
    logic signed [15:0] out_second;
    logic               out_loop;
    logic               out_end;
    logic               cfg_ready;

    // Predictor state.
    logic [15:0] blk_limit = 16'h0000;
    logic [3:0]  pos = 4'd0;
    logic [2:0]  pred_sel = 3'd0;
    logic [3:0]  shamt = 4'd0;
    logic [31:0] hist1 = 32'd0;
    logic [31:0] hist2 = 32'd0;
    logic [15:0] blocks_seen = 16'd0;
    logic        halted = 1'b0;
    logic        loop_armed = 1'b0;

    t_pair pairs_due[$];

    int  items_used = 0;
    int  mismatches = 0;
    int  pairs_checked = 0;
    int  ends_checked = 0;
    int  cfg_writes = 0;
    int  cycles = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  hold_asks = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_phase = 4'd0;
    int  pattern_age = 0;

    vag_adpcm_block_decoder i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_byte_value    (in_byte),
        .i_first_byte    (in_first),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_sample_first  (out_first),
        .o_sample_second (out_second),
        .o_loop_point    (out_loop),
        .o_stream_end    (out_end),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_block_count   (cfg_count)
    );

    always #4 clk = ~clk;

    function automatic logic signed [31:0] tap_one(input logic [2:0] sel);
        case (sel)
            3'd1: tap_one = 32'sd60;
            3'd2: tap_one = 32'sd115;
            3'd3: tap_one = 32'sd98;
            3'd4: tap_one = 32'sd122;
            default: tap_one = 32'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] tap_two(input logic [2:0] sel);
        case (sel)
            3'd2: tap_two = -32'sd52;
            3'd3: tap_two = -32'sd55;
            3'd4: tap_two = -32'sd60;
            default: tap_two = 32'sd0;
        endcase
    endfunction

    function automatic logic [31:0] filtered(input logic [3:0] nib, input logic [31:0] h_a,
                                             input logic [31:0] h_b);
        logic signed [31:0] raw;
        logic signed [31:0] acc;
        raw = {{16{nib[3]}}, nib, 12'h000};
        acc = $signed(h_a) * tap_one(pred_sel) + $signed(h_b) * tap_two(pred_sel);
        filtered = (raw >>> shamt) + (acc >>> 6);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic first);
        t_pair res;
        logic [31:0] s1;
        logic [31:0] s2;
        res = '0;
        if (first) begin
            hist1 = 32'd0;
            hist2 = 32'd0;
            pos = 4'd0;
            blocks_seen = 16'd0;
            halted = 1'b0;
            loop_armed = 1'b0;
        end
        if (!halted) begin
            if (pos == 4'd0) begin
                if (blocks_seen >= blk_limit || b[7:4] == 4'd7) begin
                    res.end_flag = 1'b1;
                    halted = 1'b1;
                    pairs_due.push_back(res);
                end else begin
                    pred_sel = (b[7:4] < 4'd5) ? b[6:4] : 3'd0;
                    shamt = b[3:0];
                    pos = 4'd1;
                end
            end else if (pos == 4'd1) begin
                if (b[0]) begin
                    res.end_flag = 1'b1;
                    halted = 1'b1;
                    pairs_due.push_back(res);
                end else begin
                    if (b[2])
                        loop_armed = 1'b1;
                    pos = 4'd2;
                end
            end else begin
                s1 = filtered(b[3:0], hist1, hist2);
                s2 = filtered(b[7:4], s1, hist1);
                hist2 = s1;
                hist1 = s2;
                res.s_first = s1[15:0];
                res.s_second = s2[15:0];
                res.loop_pt = loop_armed;
                loop_armed = 1'b0;
                if (pos == 4'd15) begin
                    pos = 4'd0;
                    if (blocks_seen != 16'hFFFF)
                        blocks_seen++;
                    if (blocks_seen >= blk_limit) begin
                        res.end_flag = 1'b1;
                        halted = 1'b1;
                    end
                end else begin
                    pos = pos + 4'd1;
                end
                pairs_due.push_back(res);
            end
        end
    endfunction

    // Receiver: a stall pattern of its own, with a long hold whenever one is requested.
    always @(posedge clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= stall_pattern[stall_phase];
        end
        stall_phase <= stall_phase + 4'd1;
        if (pattern_age == 200) begin
            pattern_age <= 0;
            case ($urandom_range(0, 3))
                0: stall_pattern <= 16'hFFFF;
                1: stall_pattern <= 16'($urandom) | 16'($urandom);
                default: stall_pattern <= 16'($urandom);
            endcase
        end else begin
            pattern_age <= pattern_age + 1;
        end
    end

    always @(posedge clk) begin : check_pairs
        t_pair want;
        if (rst_n && out_valid && out_ready) begin
            if (pairs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: first %0d second %0d loop %0b end %0b",
                             out_first, out_second, out_loop, out_end);
            end else begin
                want = pairs_due.pop_front();
                if (want.end_flag)
                    ends_checked++;
                else
                    pairs_checked++;
                if (out_first !== want.s_first || out_second !== want.s_second
                        || out_loop !== want.loop_pt || out_end !== want.end_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d %0d loop %0b end %0b, got %0d %0d loop %0b end %0b",
                                 want.s_first, want.s_second, want.loop_pt, want.end_flag,
                                 out_first, out_second, out_loop, out_end);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped by the cycle limit with %0d results outstanding",
                     pairs_due.size());
            $display("[vag_adpcm_block_decoder] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_first <= first;
        do @(posedge clk); while (!in_ready);
        items_used++;
        decode_byte(b, first);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pairs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_block_count(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        blk_limit = value;
        cfg_writes++;
    endtask

    task automatic send_stream(input int nblocks, input bit restart);
        logic [7:0] hdr;
        logic [7:0] flg;
        int k;
        int j;
        for (k = 0; k < nblocks; k++) begin
            case ($urandom_range(0, 19))
                0: hdr = {4'd7, 4'($urandom)};
                1, 2: hdr = {4'($urandom_range(5, 15)), 4'($urandom)};
                default: hdr = {1'b0, 3'($urandom_range(0, 4)), 4'($urandom)};
            endcase
            send_byte(hdr, restart && k == 0);
            flg = 8'($urandom);
            flg[0] = ($urandom_range(0, 15) == 0);
            send_byte(flg, 1'b0);
            for (j = 0; j < 14; j++)
                send_byte(8'($urandom), ($urandom_range(0, 199) == 0));
        end
        repeat ($urandom_range(0, 2))
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_full_block;
        logic [7:0] data_bytes [14];
        int j;
        data_bytes = '{8'h00, 8'hFF, 8'h80, 8'h08, 8'h7F, 8'hF7, 8'h77,
                       8'h88, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h11, 8'hEE};
        write_block_count(16'd1);
        send_byte(8'h10, 1'b1);
        send_byte(8'h04, 1'b0);
        for (j = 0; j < 14; j++)
            send_byte(data_bytes[j], 1'b0);
        drain();
    endtask

    task automatic test_stream_ends;
        write_block_count(16'd0);
        send_byte(8'h2C, 1'b1);
        send_byte(8'h33, 1'b0);
        write_block_count(16'd3);
        send_byte(8'h70, 1'b1);
        send_byte(8'h4F, 1'b1);
        send_byte(8'h05, 1'b0);
        drain();
    endtask

    task automatic test_output_hold;
        int j;
        write_block_count(16'hFFFF);
        gaps_on = 1'b0;
        hold_asks <= hold_asks + 1;
        send_byte(8'h31, 1'b1);
        send_byte(8'h00, 1'b0);
        for (j = 0; j < 14; j++)
            send_byte(8'($urandom), 1'b0);
        send_stream(2, 1'b0);
        drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_streams;
        logic [15:0] limit;
        while (items_used < ITEMS_TARGET) begin
            case ($urandom_range(0, 7))
                0: limit = 16'd0;
                1: limit = 16'hFFFF;
                2: limit = 16'd1;
                default: limit = 16'($urandom_range(1, 4));
            endcase
            write_block_count(limit);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3))
                send_stream($urandom_range(1, 4), ($urandom_range(0, 3) != 0));
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stream_ends();
        test_full_block();
        test_output_hold();
        test_random_streams();
        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d stream bytes, checked %0d sample pairs and %0d stream ends,",
                 items_used, pairs_checked, ends_checked);
        $display("across %0d block count settings with sender gaps and receiver stalls.",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("[vag_adpcm_block_decoder] OK");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("[vag_adpcm_block_decoder] ERROR");
        end
        $finish;
    end

endmodule

// ===== vag_adpcm_block_decoder.f =====
+incdir+rtl
rtl/vag_pkg.sv
rtl/vag_front.sv
rtl/vag_queue.sv
rtl/vag_back.sv
rtl/vag_adpcm_block_decoder.sv
sim/tb_top.sv
